// ===== hdl/tsi_pkg.sv =====
// ----------------------------------------------------------------------------
// tsi_pkg
// shared constants for the timestamped sample interpolator
// ----------------------------------------------------------------------------
package tsi_pkg;
   localparam int unsigned DEPTH = 16;
   localparam int unsigned AW    = $clog2(DEPTH);
   localparam int unsigned CW    = $clog2(DEPTH + 1);

   localparam logic [1:0] MODE_APPEND = 2'd0;
   localparam logic [1:0] MODE_QUERY  = 2'd1;
   localparam logic [1:0] MODE_PRUNE  = 2'd2;

   localparam logic [2:0] ST_INTERP = 3'd0;
   localparam logic [2:0] ST_LAST   = 3'd1;
   localparam logic [2:0] ST_FIRST  = 3'd2;
   localparam logic [2:0] ST_EXTRAP = 3'd3;
   localparam logic [2:0] ST_SINGLE = 3'd4;
   localparam logic [2:0] ST_NODATA = 3'd5;

   localparam logic [CW-1:0] KEEP_MIN  = CW'(3);
   localparam logic [AW-1:0] PRUNE_REF = AW'(2);
endpackage

// ===== hdl/timestamped_sample_interpolator.sv =====
// ----------------------------------------------------------------------------
// timestamped_sample_interpolator
// ring of time-stamped samples with append, prune and interpolating query
// ----------------------------------------------------------------------------
// channel   direction  ports
// request   in/out     start, busy (out), req_mode, req_time_stamp, req_sample_value
// response  out        rsp_valid, rsp_result_value, rsp_result_time, rsp_status
//
// one transaction at a time; busy is high from the cycle after acceptance to completion
// append: busy for one ring read (none on an empty ring); prune: one ring read per sample checked,
// so one read per dropped sample plus at most one more
// query: a ring read each for the endpoints, the walk and the pair, a multiply step, then a
// 65-step restoring divider to extrapolate or interpolate
// early, last, single and empty answers come after the endpoint reads or at once
// all samples sit in one (time,value) ram with one read/write port and a registered read
// reset clears the control registers only; ram contents stay undefined
// results are a one-cycle strobe; the receiver cannot stall
// ----------------------------------------------------------------------------
module timestamped_sample_interpolator (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_time_stamp,
   input  logic signed [31:0] req_sample_value,
   output logic        rsp_valid,
   output logic signed [31:0] rsp_result_value,
   output logic [31:0] rsp_result_time,
   output logic [2:0]  rsp_status
);
   localparam int unsigned AW = tsi_pkg::AW;
   localparam int unsigned CW = tsi_pkg::CW;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_RD    = 11'b00000000010,  // address presented, wait for data
      S_APP   = 11'b00000000100,
      S_PRN   = 11'b00000001000,
      S_QF    = 11'b00000010000,  // got first
      S_QL    = 11'b00000100000,  // got last
      S_QW    = 11'b00001000000,  // walk step
      S_QP0   = 11'b00010000000,  // got pair low
      S_QP1   = 11'b00100000000,  // got pair high
      S_MUL   = 11'b01000000000,
      S_DIV   = 11'b10000000000
   } state_type;

   typedef enum logic [2:0] {
      R_APP, R_PRN, R_QF, R_QL, R_QW, R_QP0, R_QP1
   } ret_type;

   state_type    state_ff, state_in;
   ret_type      ret_ff, ret_in;
   logic [AW-1:0] oldest_ff, oldest_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] spos_ff, spos_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic         wdir_ff, wdir_in;     // walk direction, 1 = up
   logic [31:0]  t_ff, t_in;
   logic signed [31:0] sv_ff, sv_in;
   logic [31:0]  t0_ff, t0_in, tf_ff, tf_in;
   logic signed [31:0] v0_ff, v0_in, vf_ff, vf_in;
   logic [31:0]  t1_ff, t1_in;
   logic signed [31:0] v1_ff, v1_in;
   logic [2:0]   st_ff, st_in;
   logic [64:0]  num_ff, num_in;
   logic [32:0]  mag_ff, mag_in;
   logic [32:0]  rem_ff, rem_in;
   logic [40:0]  quo_ff, quo_in;
   logic [6:0]   bit_ff, bit_in;
   logic         neg_ff, neg_in;
   logic         rv_ff, rv_in;
   logic signed [31:0] rvl_ff, rvl_in;
   logic [31:0]  rtm_ff, rtm_in;
   logic [2:0]   rst_ff, rst_in;

   logic          we;
   logic [AW-1:0] addr;
   logic [63:0]   wdata, rdata;
   logic [AW-1:0] raddr_ff, raddr_in;

   tsi_ram #(.WIDTH(64), .DEPTH(tsi_pkg::DEPTH)) u_ram (
      .clock (clock), .we (we), .addr (addr), .wdata (wdata), .rdata (rdata)
   );

   function automatic logic [AW-1:0] slot(input logic [AW-1:0] o, input logic [CW-1:0] l);
      logic [CW:0] s;
      s = CW'(o) + l;
      return AW'(s % tsi_pkg::DEPTH);
   endfunction

   logic [31:0] rt;
   logic signed [31:0] rvv;
   logic [CW-1:0] nm1;
   logic [33:0]  rsh;
   logic [41:0]  qn;
   logic signed [42:0] sum;
   logic signed [32:0] dif;

   assign rt  = rdata[63:32];
   assign rvv = rdata[31:0];
   assign nm1 = count_ff - CW'(1);
   assign busy = (state_ff != S_IDLE);
   assign rsp_valid        = rv_ff;
   assign rsp_result_value = rvl_ff;
   assign rsp_result_time  = rtm_ff;
   assign rsp_status       = rst_ff;

   always_comb begin
      state_in = state_ff; ret_in = ret_ff; oldest_in = oldest_ff;
      count_in = count_ff; spos_in = spos_ff; pos_in = pos_ff; wdir_in = wdir_ff;
      t_in = t_ff; sv_in = sv_ff;
      t0_in = t0_ff; v0_in = v0_ff; t1_in = t1_ff; v1_in = v1_ff;
      tf_in = tf_ff; vf_in = vf_ff; st_in = st_ff;
      num_in = num_ff; mag_in = mag_ff; rem_in = rem_ff; quo_in = quo_ff;
      bit_in = bit_ff; neg_in = neg_ff;
      rv_in = 1'b0; rvl_in = rvl_ff; rtm_in = rtm_ff; rst_in = rst_ff;
      we = 1'b0; addr = raddr_ff; wdata = {t_ff, sv_ff}; raddr_in = raddr_ff;
      rsh = '0; qn = '0; sum = '0; dif = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               t_in = req_time_stamp; sv_in = req_sample_value;
               if (spos_ff >= AW'(count_ff) && count_ff != '0 &&
                   count_ff != CW'(tsi_pkg::DEPTH) && req_mode == tsi_pkg::MODE_QUERY) begin
                  spos_in = AW'(count_ff - CW'(1));
               end
               unique case (req_mode)
                  tsi_pkg::MODE_APPEND: begin
                     if (count_ff == '0) begin
                        we = 1'b1; addr = slot(oldest_ff, '0);
                        wdata = {req_time_stamp, req_sample_value};
                        count_in = CW'(1);
                     end else begin
                        raddr_in = slot(oldest_ff, nm1); ret_in = R_APP; state_in = S_RD;
                     end
                  end
                  tsi_pkg::MODE_PRUNE: begin
                     if (count_ff > tsi_pkg::KEEP_MIN) begin
                        raddr_in = slot(oldest_ff, CW'(tsi_pkg::PRUNE_REF));
                        ret_in = R_PRN; state_in = S_RD;
                     end
                  end
                  tsi_pkg::MODE_QUERY: begin
                     if (count_ff == '0) begin
                        rv_in = 1'b1; rvl_in = '0; rtm_in = req_time_stamp;
                        rst_in = tsi_pkg::ST_NODATA;
                     end else begin
                        raddr_in = oldest_ff; ret_in = R_QF; state_in = S_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_RD: begin
            unique case (ret_ff)
               R_APP: state_in = S_APP;
               R_PRN: state_in = S_PRN;
               R_QF:  state_in = S_QF;
               R_QL:  state_in = S_QL;
               R_QW:  state_in = S_QW;
               R_QP0: state_in = S_QP0;
               default: state_in = S_QP1;
            endcase
         end
         S_APP: begin
            state_in = S_IDLE;
            if (!(t_ff < rt)) begin
               we = 1'b1;
               if (count_ff < CW'(tsi_pkg::DEPTH)) begin
                  addr = slot(oldest_ff, count_ff); count_in = count_ff + CW'(1);
               end else begin
                  addr = oldest_ff; oldest_in = slot(oldest_ff, CW'(1));
               end
            end
         end
         S_PRN: begin
            if (t_ff > rt) begin
               oldest_in = slot(oldest_ff, CW'(1)); count_in = count_ff - CW'(1);
               if (count_ff - CW'(1) > tsi_pkg::KEEP_MIN) begin
                  raddr_in = slot(oldest_ff, CW'(tsi_pkg::PRUNE_REF + 1'b1));
                  state_in = S_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         S_QF: begin
            tf_in = rt; vf_in = rvv;
            raddr_in = slot(oldest_ff, nm1); ret_in = R_QL; state_in = S_RD;
         end
         S_QL: begin
            state_in = S_IDLE;
            if (spos_ff >= AW'(count_ff) && count_ff < CW'(tsi_pkg::DEPTH)) begin
               spos_in = AW'(nm1);
            end
            if (t_ff >= tf_ff && t_ff < rt) begin
               pos_in = (spos_ff >= AW'(count_ff) && count_ff < CW'(tsi_pkg::DEPTH))
                        ? AW'(nm1) : spos_ff;
               wdir_in = 1'b1;
               raddr_in = slot(oldest_ff, CW'(pos_in)); ret_in = R_QW; state_in = S_RD;
            end else if (t_ff <= tf_ff) begin
               rv_in = 1'b1; rvl_in = vf_ff; rtm_in = tf_ff; rst_in = tsi_pkg::ST_FIRST;
            end else if (t_ff == rt) begin
               rv_in = 1'b1; rvl_in = rvv; rtm_in = rt; rst_in = tsi_pkg::ST_LAST;
            end else if (count_ff > CW'(1)) begin
               st_in = tsi_pkg::ST_EXTRAP; t1_in = rt; v1_in = rvv;
               raddr_in = slot(oldest_ff, count_ff - CW'(2)); ret_in = R_QP0;
               state_in = S_RD;
            end else begin
               rv_in = 1'b1; rvl_in = vf_ff; rtm_in = tf_ff; rst_in = tsi_pkg::ST_SINGLE;
            end
         end
         S_QW: begin
            // up pass while time < t, then down pass while time > t
            if (wdir_ff && CW'(pos_ff) < nm1 && rt < t_ff) begin
               pos_in = pos_ff + AW'(1);
               raddr_in = slot(oldest_ff, CW'(pos_in)); state_in = S_RD;
            end else if (pos_ff != '0 && rt > t_ff) begin
               wdir_in = 1'b0; pos_in = pos_ff - AW'(1);
               raddr_in = slot(oldest_ff, CW'(pos_in)); state_in = S_RD;
            end else begin
               pos_in = (CW'(pos_ff) > count_ff - CW'(2)) ? AW'(count_ff - CW'(2)) : pos_ff;
               spos_in = pos_in; st_in = tsi_pkg::ST_INTERP;
               raddr_in = slot(oldest_ff, CW'(pos_in) + CW'(1)); ret_in = R_QP1;
               state_in = S_RD;
            end
         end
         S_QP1: begin
            t1_in = rt; v1_in = rvv;
            raddr_in = slot(oldest_ff, CW'(pos_ff)); ret_in = R_QP0; state_in = S_RD;
         end
         S_QP0: begin
            t0_in = rt; v0_in = rvv;
            dif = 33'(v1_ff) - 33'(rvv);
            neg_in = dif[32];
            mag_in = dif[32] ? 33'(-dif) : 33'(dif);
            state_in = S_MUL;
         end
         S_MUL: begin
            rtm_in = t_ff;
            if (t1_ff <= t0_ff) begin
               rv_in = 1'b1; rvl_in = v1_ff; rst_in = st_ff; state_in = S_IDLE;
            end else begin
               num_in = 65'(mag_ff[31:0] * (t_ff - t0_ff)) +
                        (mag_ff[32] ? {1'b0, t_ff - t0_ff, 32'd0} : 65'd0);
               rem_in = '0; quo_in = '0; bit_in = 7'd64; state_in = S_DIV;
            end
         end
         S_DIV: begin
            // quotient kept one bit wider so a capped value shifts past the cap
            rsh = {rem_ff, num_ff[bit_ff]};
            qn = {quo_ff, 1'b0};
            if (rsh >= {2'b00, t1_ff - t0_ff}) begin
               rsh = rsh - {2'b00, t1_ff - t0_ff};
               qn[0] = 1'b1;
            end
            if (qn > 42'h100_0000_0000) qn = 42'h100_0000_0000;
            rem_in = rsh[32:0]; quo_in = qn[40:0];
            if (bit_ff == '0) begin
               sum = neg_ff ? 43'(v0_ff) - $signed({2'b00, qn[40:0]})
                            : 43'(v0_ff) + $signed({2'b00, qn[40:0]});
               if (sum > 43'sd2147483647) rvl_in = 32'sh7fffffff;
               else if (sum < -43'sd2147483648) rvl_in = 32'sh80000000;
               else rvl_in = sum[31:0];
               rv_in = 1'b1; rst_in = st_ff; state_in = S_IDLE;
            end else begin
               bit_in = bit_ff - 7'd1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; oldest_ff <= '0; count_ff <= '0; spos_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; oldest_ff <= oldest_in; count_ff <= count_in;
         spos_ff <= spos_in; rv_ff <= rv_in;
      end
      ret_ff <= ret_in; pos_ff <= pos_in; wdir_ff <= wdir_in;
      t_ff <= t_in; sv_ff <= sv_in; t0_ff <= t0_in; v0_ff <= v0_in;
      t1_ff <= t1_in; v1_ff <= v1_in; tf_ff <= tf_in; vf_ff <= vf_in;
      st_ff <= st_in; num_ff <= num_in;
      mag_ff <= mag_in; rem_ff <= rem_in; quo_ff <= quo_in; bit_ff <= bit_in;
      neg_ff <= neg_in; rvl_ff <= rvl_in; rtm_ff <= rtm_in; rst_ff <= rst_in;
      raddr_ff <= raddr_in;
   end
endmodule

// ===== hdl/tsi_ram.sv =====
// ----------------------------------------------------------------------------
// tsi_ram
// single port synchronous ram, registered read
// ----------------------------------------------------------------------------
module tsi_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule
